// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the line rasterizer RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line rasterizer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line rasterizer: next-cycle check failed");

`endif

// ----- rtl/mle_zone_pkg.sv -----
// Package for the eight-zone midpoint line rasterizer: widths, beat types,
// opcodes and the zone mapping functions. Depends on nothing.
package mle_zone_pkg;

  localparam int COORD_BITS = 12;
  localparam int WALK_W     = COORD_BITS + 1;
  localparam int AXIS_W     = COORD_BITS + 2;
  localparam int DIAG_W     = COORD_BITS + 3;
  localparam int DEC_W      = COORD_BITS + 4;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef logic [2:0] zone_t;
  localparam zone_t ZONE_0 = 3'd0;
  localparam zone_t ZONE_1 = 3'd1;
  localparam zone_t ZONE_2 = 3'd2;
  localparam zone_t ZONE_3 = 3'd3;
  localparam zone_t ZONE_4 = 3'd4;
  localparam zone_t ZONE_5 = 3'd5;
  localparam zone_t ZONE_6 = 3'd6;
  localparam zone_t ZONE_7 = 3'd7;

  typedef struct packed {
    opcode_t                        opcode;
    logic signed [COORD_BITS-1:0]   x_start;
    logic signed [COORD_BITS-1:0]   y_start;
    logic signed [COORD_BITS-1:0]   x_end;
    logic signed [COORD_BITS-1:0]   y_end;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]   pixel_x;
    logic signed [COORD_BITS-1:0]   pixel_y;
    zone_t                          octant;
    logic                           final_pixel;
  } pix_t;

  typedef struct packed {
    logic signed [WALK_W-1:0] a;
    logic signed [WALK_W-1:0] b;
  } pt_t;

  // Zones 1, 2, 5 and 6 exchange the axes.
  function automatic logic zone_swaps(input zone_t z);
    return z[0] ^ z[1];
  endfunction

  // Zones 2 through 5 mirror the x axis.
  function automatic logic zone_mirror_x(input zone_t z);
    return z[2] ^ z[1];
  endfunction

  // Zones 4 through 7 mirror the y axis.
  function automatic logic zone_mirror_y(input zone_t z);
    return z[2];
  endfunction

  function automatic zone_t pick_zone(input logic signed [WALK_W-1:0] dx,
                                      input logic signed [WALK_W-1:0] dy);
    zone_t z;
    if (!dx[WALK_W-1] && !dy[WALK_W-1]) begin
      z = (dx >= dy) ? ZONE_0 : ZONE_1;
    end else if (dx[WALK_W-1] && !dy[WALK_W-1]) begin
      z = (dy > -dx) ? ZONE_2 : ZONE_3;
    end else if (dx[WALK_W-1]) begin
      z = (-dx >= -dy) ? ZONE_4 : ZONE_5;
    end else begin
      z = (dx >= -dy) ? ZONE_7 : ZONE_6;
    end
    return z;
  endfunction

  function automatic pt_t to_zone0(input zone_t z,
                                   input logic signed [WALK_W-1:0] x,
                                   input logic signed [WALK_W-1:0] y);
    pt_t p;
    if (zone_swaps(z)) begin
      p.a = zone_mirror_y(z) ? -y : y;
      p.b = zone_mirror_x(z) ? -x : x;
    end else begin
      p.a = zone_mirror_x(z) ? -x : x;
      p.b = zone_mirror_y(z) ? -y : y;
    end
    return p;
  endfunction

  function automatic pt_t from_zone0(input zone_t z,
                                     input logic signed [WALK_W-1:0] a,
                                     input logic signed [WALK_W-1:0] b);
    pt_t p;
    logic signed [WALK_W-1:0] x;
    logic signed [WALK_W-1:0] y;
    x = zone_swaps(z) ? b : a;
    y = zone_swaps(z) ? a : b;
    p.a = zone_mirror_x(z) ? -x : x;
    p.b = zone_mirror_y(z) ? -y : y;
    return p;
  endfunction

endpackage

// ----- rtl/midpoint_line_eight_zone.sv -----
// Eight-zone midpoint line rasterizer, top level; uses mle_zone_pkg and
// assert_macros.svh. A load beat (opcode OP_LOAD) carries two signed
// endpoints and gives no pixel; it classifies the line into one of eight
// zones, folds it into zone 0 and replaces any line still being walked.
// Every step beat (opcode OP_STEP) then gives exactly one pixel beat, in
// original coordinates, with the zone as octant and final_pixel set on the
// end point; after that pixel, and while no line is loaded, step beats are
// consumed without a result. Equal endpoints give a single final pixel.
// The walk state feeds one add and compare and the zone unmapping,
// straight into the pixel output register, so a beat can be accepted
// every cycle and its pixel is valid in the cycle after the step.
// The command side stalls only while a pixel sits in the output register
// and the consumer is not taking it.
`include "assert_macros.svh"

module midpoint_line_eight_zone
  import mle_zone_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic pix_valid,
  input  logic pix_ready,
  output pix_t pix
);

  // Walk state, all in zone 0 coordinates.
  logic signed [WALK_W-1:0] walk_x;
  logic signed [WALK_W-1:0] walk_y;
  logic signed [WALK_W-1:0] stop_x;
  logic signed [DEC_W-1:0]  decision;
  logic signed [AXIS_W-1:0] axis_increment;
  logic signed [DIAG_W-1:0] diagonal_increment;
  zone_t                    line_zone;
  logic                     line_active;

  logic cmd_fire;
  logic step_emit;

  // Load path: classification and folding of both endpoints.
  logic signed [WALK_W-1:0] x1_ext, y1_ext, x2_ext, y2_ext;
  logic signed [WALK_W-1:0] dx_raw, dy_raw;
  zone_t                    load_zone;
  pt_t                      p_start, p_end;
  logic signed [WALK_W-1:0] dx0, dy0;

  // Step path.
  logic                     at_end;
  pt_t                      p_orig;
  pix_t                     pix_next;
  logic signed [DEC_W-1:0]  decision_next;

  // The output register frees up when empty or drained this cycle.
  assign cmd_ready = !pix_valid || pix_ready;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign step_emit = cmd_fire && (cmd.opcode == OP_STEP) && line_active;

  always_comb begin
    x1_ext    = WALK_W'(cmd.x_start);
    y1_ext    = WALK_W'(cmd.y_start);
    x2_ext    = WALK_W'(cmd.x_end);
    y2_ext    = WALK_W'(cmd.y_end);
    dx_raw    = x2_ext - x1_ext;
    dy_raw    = y2_ext - y1_ext;
    load_zone = pick_zone(dx_raw, dy_raw);
    p_start   = to_zone0(load_zone, x1_ext, y1_ext);
    p_end     = to_zone0(load_zone, x2_ext, y2_ext);
    // In zone 0 both differences are non-negative and dx0 >= dy0.
    dx0       = p_end.a - p_start.a;
    dy0       = p_end.b - p_start.b;
  end

  always_comb begin
    at_end               = (walk_x == stop_x);
    p_orig               = from_zone0(line_zone, walk_x, walk_y);
    pix_next.pixel_x     = p_orig.a[COORD_BITS-1:0];
    pix_next.pixel_y     = p_orig.b[COORD_BITS-1:0];
    pix_next.octant      = line_zone;
    pix_next.final_pixel = at_end;
    // A tie on the decision variable takes the diagonal step.
    if (decision[DEC_W-1]) begin
      decision_next = decision + DEC_W'(axis_increment);
    end else begin
      decision_next = decision + DEC_W'(diagonal_increment);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x             <= '0;
      walk_y             <= '0;
      stop_x             <= '0;
      decision           <= '0;
      axis_increment     <= '0;
      diagonal_increment <= '0;
      line_zone          <= ZONE_0;
      line_active        <= 1'b0;
    end else if (cmd_fire) begin
      case (cmd.opcode)
        OP_LOAD: begin
          walk_x             <= p_start.a;
          walk_y             <= p_start.b;
          stop_x             <= p_end.a;
          decision           <= (DEC_W'(dy0) <<< 1) - DEC_W'(dx0);
          axis_increment     <= AXIS_W'(dy0) <<< 1;
          diagonal_increment <= (DIAG_W'(dy0) <<< 1) - (DIAG_W'(dx0) <<< 1);
          line_zone          <= load_zone;
          line_active        <= 1'b1;
        end
        OP_STEP: begin
          if (line_active) begin
            if (at_end) begin
              line_active <= 1'b0;
            end else begin
              walk_x   <= walk_x + WALK_W'(1);
              decision <= decision_next;
              if (!decision[DEC_W-1]) begin
                walk_y <= walk_y + WALK_W'(1);
              end
            end
          end
        end
        default: begin
          line_active <= line_active;
        end
      endcase
    end
  end

  // Pixel output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (step_emit) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_emit) begin
      pix <= pix_next;
    end
  end

  `ASSERT_NEXT(a_step_gives_pixel, step_emit, pix_valid)
  `ASSERT_NEXT(a_end_pixel_idles, step_emit && at_end, !line_active && pix.final_pixel)
  `ASSERT_NEXT(a_load_arms_walk, cmd_fire && cmd.opcode == OP_LOAD, line_active)
  `ASSERT_SAME(a_walk_within_line, line_active, walk_x <= stop_x)

endmodule

// ----- bench/midpoint_line_eight_zone_tb.sv -----
// Self-checking bench for the eight-zone midpoint line rasterizer.
// Needs only mle_zone_pkg and midpoint_line_eight_zone; the pixel walk is
// predicted here and every pixel beat is checked field by field.
module midpoint_line_eight_zone_tb;
  import mle_zone_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Nothing in this run should come near this many cycles; hitting it
  // means the block hung or dropped a handshake.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BEATS = 1400;
  localparam int DIRECTED_LEN = 26;

  // How a row of the directed table is checked: against the predictor, as
  // a beat that must give nothing, or against a pixel written in the row.
  typedef enum logic [1:0] {
    BY_MODEL,
    NO_PIXEL,
    GIVEN_PIXEL
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cmd_t      c;
    pix_t      want;
  } row_t;

  localparam pix_t NO_PIX = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic pix_valid;
  logic pix_ready = 1'b0;
  pix_t pix;

  // Walk state of the predicted line, kept at the block's own widths and
  // in zone 0 coordinates.
  logic signed [WALK_W-1:0] walk_x = '0;
  logic signed [WALK_W-1:0] walk_y = '0;
  logic signed [WALK_W-1:0] walk_stop = '0;
  logic signed [DEC_W-1:0]  walk_dec = '0;
  logic signed [AXIS_W-1:0] walk_axis = '0;
  logic signed [DIAG_W-1:0] walk_diag = '0;
  zone_t                    walk_zone = ZONE_0;
  logic                     walk_busy = 1'b0;

  pix_t pixels_due[$];
  int   errors = 0;
  int   cycles = 0;
  int   beats_sent = 0;
  int   hold_left = 0;
  // While calm is set, neither side inserts bubbles or stalls, so some
  // stretches run at the full beat-per-cycle rate.
  bit   calm = 1'b0;
  row_t directed [DIRECTED_LEN];

  midpoint_line_eight_zone uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  always #5 clk = ~clk;

  // Bubble and stall lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Zone of a line from its deltas; zones run counter-clockwise from the
  // shallow rising zone, and the boundary cases fall as the block defines them.
  function automatic zone_t classify(input int dx, input int dy);
    int adx;
    int ady;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (dy >= 0) begin
      if (dx >= 0) return (adx >= ady) ? ZONE_0 : ZONE_1;
      return (ady > adx) ? ZONE_2 : ZONE_3;
    end
    if (dx < 0) return (adx >= ady) ? ZONE_4 : ZONE_5;
    return (adx >= ady) ? ZONE_7 : ZONE_6;
  endfunction

  // Fold an original point into zone 0 coordinates.
  function automatic void fold(input zone_t z, input int x, input int y,
                               output int a, output int b);
    case (z)
      ZONE_0: begin a = x;  b = y;  end
      ZONE_1: begin a = y;  b = x;  end
      ZONE_2: begin a = y;  b = -x; end
      ZONE_3: begin a = -x; b = y;  end
      ZONE_4: begin a = -x; b = -y; end
      ZONE_5: begin a = -y; b = -x; end
      ZONE_6: begin a = -y; b = x;  end
      default: begin a = x; b = -y; end
    endcase
  endfunction

  // Inverse of fold: a zone 0 point back to original coordinates.
  function automatic void unfold(input zone_t z, input int a, input int b,
                                 output int x, output int y);
    case (z)
      ZONE_0: begin x = a;  y = b;  end
      ZONE_1: begin x = b;  y = a;  end
      ZONE_2: begin x = -b; y = a;  end
      ZONE_3: begin x = -a; y = b;  end
      ZONE_4: begin x = -a; y = -b; end
      ZONE_5: begin x = -b; y = -a; end
      ZONE_6: begin x = b;  y = -a; end
      default: begin x = a; y = -b; end
    endcase
  endfunction

  // Advance the predicted rasterizer by one accepted command beat. A load
  // sets up the midpoint walk; a step emits the current point and moves on.
  function automatic void rasterize_beat(input cmd_t c, output bit gives,
                                         output pix_t p);
    int x0;
    int y0;
    int x1;
    int y1;
    int ax;
    int ay;
    int bx;
    int by;
    int px;
    int py;
    gives = 1'b0;
    p = '0;
    if (c.opcode == OP_LOAD) begin
      x0 = int'(c.x_start);
      y0 = int'(c.y_start);
      x1 = int'(c.x_end);
      y1 = int'(c.y_end);
      walk_zone = classify(x1 - x0, y1 - y0);
      fold(walk_zone, x0, y0, ax, ay);
      fold(walk_zone, x1, y1, bx, by);
      walk_x    = WALK_W'(ax);
      walk_y    = WALK_W'(ay);
      walk_stop = WALK_W'(bx);
      walk_dec  = DEC_W'(2 * (by - ay) - (bx - ax));
      walk_axis = AXIS_W'(2 * (by - ay));
      walk_diag = DIAG_W'(2 * (by - ay) - 2 * (bx - ax));
      walk_busy = 1'b1;
    end else if (walk_busy) begin
      unfold(walk_zone, int'(walk_x), int'(walk_y), px, py);
      gives = 1'b1;
      p.pixel_x = COORD_BITS'(px);
      p.pixel_y = COORD_BITS'(py);
      p.octant = walk_zone;
      p.final_pixel = (walk_x == walk_stop);
      if (walk_x == walk_stop) begin
        walk_busy = 1'b0;
      end else if (walk_dec < 0) begin
        walk_x = walk_x + WALK_W'(1);
        walk_dec = walk_dec + walk_axis;
      end else begin
        // A tie at zero takes the diagonal step.
        walk_x = walk_x + WALK_W'(1);
        walk_y = walk_y + WALK_W'(1);
        walk_dec = walk_dec + walk_diag;
      end
    end
  endfunction

  function automatic cmd_t load_cmd(input int x0, input int y0,
                                    input int x1, input int y1);
    cmd_t c;
    c.opcode  = OP_LOAD;
    c.x_start = COORD_BITS'(x0);
    c.y_start = COORD_BITS'(y0);
    c.x_end   = COORD_BITS'(x1);
    c.y_end   = COORD_BITS'(y1);
    return c;
  endfunction

  function automatic cmd_t step_cmd();
    cmd_t c;
    c = '0;
    c.opcode = OP_STEP;
    return c;
  endfunction

  // Any bit pattern at all; callers force the opcode when they need one.
  function automatic cmd_t random_cmd();
    return cmd_t'(($bits(cmd_t))'({$urandom, $urandom}));
  endfunction

  function automatic pix_t pixel(input int x, input int y, input zone_t z,
                                 input bit last);
    pix_t p;
    p.pixel_x = COORD_BITS'(x);
    p.pixel_y = COORD_BITS'(y);
    p.octant = z;
    p.final_pixel = last;
    return p;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 100) begin
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // Present one command beat and hold it until the block takes it, then
  // book the pixel it should cause. Called at a rising edge; returns at the
  // edge where the beat was accepted. A bubble drops valid first; with no
  // bubble valid simply stays high for the new payload.
  task automatic issue(input cmd_t c, input row_kind_t kind, input pix_t want);
    int   gap;
    bit   gives;
    pix_t p;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!(cmd_valid && cmd_ready));
    rasterize_beat(c, gives, p);
    if (kind == GIVEN_PIXEL) begin
      pixels_due.push_back(want);
    end else if (kind == BY_MODEL && gives) begin
      pixels_due.push_back(p);
    end
    if (c.opcode == OP_LOAD || gives) beats_sent++;
  endtask

  task automatic random_step();
    cmd_t c;
    c = random_cmd();
    c.opcode = OP_STEP;
    issue(c, BY_MODEL, NO_PIX);
  endtask

  // Pixel side: take beats when ready is high and compare each one with
  // the oldest pixel still owed. Ready is re-drawn each time a stall has run
  // out, so stalls of varied length land on every phase of the walk.
  always @(posedge clk) begin
    pix_t want;
    if (!rst && pix_valid && pix_ready) begin
      if (pixels_due.size() == 0) begin
        report("pixel beat with none pending, x", int'(pix.pixel_x), 0);
      end else begin
        want = pixels_due.pop_front();
        if (pix.pixel_x !== want.pixel_x)
          report("pixel_x", int'(pix.pixel_x), int'(want.pixel_x));
        if (pix.pixel_y !== want.pixel_y)
          report("pixel_y", int'(pix.pixel_y), int'(want.pixel_y));
        if (pix.octant !== want.octant)
          report("octant", int'(pix.octant), int'(want.octant));
        if (pix.final_pixel !== want.final_pixel)
          report("final_pixel", int'(pix.final_pixel), int'(want.final_pixel));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_ready <= 1'b0;
    end else begin
      hold_left = pick_gap();
      pix_ready <= (hold_left == 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("midpoint_line_eight_zone_tb: errors");
      $finish;
    end
  end

  initial begin
    int seq;
    int r;
    int x0;
    int y0;
    int len;
    int dx;
    int dy;
    int stop_after;
    int n;
    cmd_t c;

    // Directed rows: a step with nothing loaded, a single-point line, the
    // corners of the coordinate space in both directions, a load that
    // replaces a line mid-walk, a tie on the decision, and one short line
    // in each of the remaining zones.
    directed = '{
      '{NO_PIXEL,    step_cmd(),                         NO_PIX},
      '{NO_PIXEL,    load_cmd(5, -7, 5, -7),             NO_PIX},
      '{GIVEN_PIXEL, step_cmd(),                         pixel(5, -7, ZONE_0, 1'b1)},
      '{NO_PIXEL,    step_cmd(),                         NO_PIX},
      '{NO_PIXEL,    load_cmd(-2048, -2048, 2047, 2047), NO_PIX},
      '{GIVEN_PIXEL, step_cmd(),                         pixel(-2048, -2048, ZONE_0, 1'b0)},
      '{BY_MODEL,    step_cmd(),                         NO_PIX},
      '{NO_PIXEL,    load_cmd(2047, 2047, -2048, -2048), NO_PIX},
      '{GIVEN_PIXEL, step_cmd(),                         pixel(2047, 2047, ZONE_4, 1'b0)},
      '{NO_PIXEL,    load_cmd(-2048, 2047, 2047, -2048), NO_PIX},
      '{GIVEN_PIXEL, step_cmd(),                         pixel(-2048, 2047, ZONE_7, 1'b0)},
      '{NO_PIXEL,    load_cmd(0, 2047, 0, -2048),        NO_PIX},
      '{GIVEN_PIXEL, step_cmd(),                         pixel(0, 2047, ZONE_6, 1'b0)},
      '{BY_MODEL,    step_cmd(),                         NO_PIX},
      '{BY_MODEL,    load_cmd(0, 0, 2, 1),               NO_PIX},
      '{BY_MODEL,    step_cmd(),                         NO_PIX},
      '{BY_MODEL,    step_cmd(),                         NO_PIX},
      '{BY_MODEL,    step_cmd(),                         NO_PIX},
      '{BY_MODEL,    load_cmd(0, 0, 1, 3),               NO_PIX},
      '{BY_MODEL,    step_cmd(),                         NO_PIX},
      '{BY_MODEL,    load_cmd(0, 0, -1, 3),              NO_PIX},
      '{BY_MODEL,    step_cmd(),                         NO_PIX},
      '{BY_MODEL,    load_cmd(3, 3, 0, 4),               NO_PIX},
      '{BY_MODEL,    step_cmd(),                         NO_PIX},
      '{BY_MODEL,    load_cmd(0, 0, -1, -3),             NO_PIX},
      '{BY_MODEL,    step_cmd(),                         NO_PIX}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      issue(directed[i].c, directed[i].kind, directed[i].want);
    end

    // Random part. Most sequences load a short line anywhere in the plane
    // and walk it to its end; some are cut short by a new load, some get
    // extra steps after the end pixel, some load arbitrary endpoints and
    // walk only a little of a long line, and the rest are stray beats.
    seq = 0;
    while (beats_sent < DIRECTED_LEN + RANDOM_BEATS) begin
      if (seq % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      seq++;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        x0 = int'($urandom_range(0, 4095)) - 2048;
        y0 = int'($urandom_range(0, 4095)) - 2048;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120)
                                           : $urandom_range(0, 12);
        dx = $urandom_range(0, len);
        dy = $urandom_range(0, len);
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        issue(load_cmd(x0, y0, clamp_coord(x0 + dx), clamp_coord(y0 + dy)),
              BY_MODEL, NO_PIX);
        stop_after = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
        n = 0;
        while (walk_busy && n != stop_after) begin
          random_step();
          n++;
        end
        if (!walk_busy && $urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 2)) random_step();
        end
      end else if (r < 90) begin
        c = random_cmd();
        c.opcode = OP_LOAD;
        issue(c, BY_MODEL, NO_PIX);
        n = $urandom_range(1, 30);
        while (walk_busy && n > 0) begin
          random_step();
          n--;
        end
      end else begin
        issue(random_cmd(), BY_MODEL, NO_PIX);
      end
    end

    // Drain: wait for every owed pixel, then let the clock run on to catch
    // anything the block sends on its own.
    cmd_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("midpoint_line_eight_zone_tb: clean");
    end else begin
      $display("midpoint_line_eight_zone_tb: errors");
    end
    $finish;
  end

endmodule
